// ===== hw/rtl/fmr_pkg.sv =====
// Package for the float32 minifloat rounding block.
// Holds register indexes, reset values and field widths; no dependencies.
`timescale 1ns / 1ps
package fmr_pkg;
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXP_WIDTH  = 2'd0,
    CFG_FRAC_WIDTH = 2'd1,
    CFG_EXP_BIAS   = 2'd2
  } cfg_idx_e;
  localparam logic [3:0] ExpWidthRst  = 4'd8;
  localparam logic [4:0] FracWidthRst = 5'd23;
  localparam logic [7:0] ExpBiasRst   = 8'd127;
endpackage

// ===== hw/rtl/float32_minifloat_round.sv =====
// Float32 rounding onto a configurable minifloat grid.
// Registers: input register, then result register.
// Throughput: one item per cycle while out_stall_i is low; the round path is one 24-bit add and a few compares.
// Reset: asynchronous, active low; clears valid bits and loads the format
// registers with 8 exponent bits, 23 fraction bits and bias 127.
// Depends on fmr_pkg.
`timescale 1ns / 1ps
module float32_minifloat_round
  import fmr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_out_o
);
  logic [3:0] ew_q;
  logic [4:0] fw_q;
  logic [7:0] bias_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ew_q   <= ExpWidthRst;
      fw_q   <= FracWidthRst;
      bias_q <= ExpBiasRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_EXP_WIDTH:  ew_q   <= cfg_data_i[3:0];
        CFG_FRAC_WIDTH: fw_q   <= cfg_data_i[4:0];
        CFG_EXP_BIAS:   bias_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Two-stage pipe; each stage advances when the next can take it.
  logic        s1_valid_q, out_valid_q;
  logic [31:0] s1_q, out_q;
  logic        s1_adv, in_acc;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) s1_valid_q <= in_valid_i;
      if (s1_adv) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s1_q <= value_in_i;
  end

  // Exponent range in signed 10-bit arithmetic, saturated to -126..127.
  logic signed [9:0] emax_raw, emin_raw, emax, emin, e, ewk, eo, ep1;
  logic [7:0]  bexp;
  logic [22:0] frac, fmask, half;
  logic [4:0]  fw, sh;
  logic [23:0] m;
  logic        is_pass;
  logic [31:0] res_d;
  logic signed [9:0] eres;
  logic [22:0] fres;

  function automatic logic signed [9:0] sat(input logic signed [9:0] v);
    if (v < -10'sd126) return -10'sd126;
    if (v > 10'sd127) return 10'sd127;
    return v;
  endfunction

  always_comb begin
    bexp     = s1_q[30:23];
    frac     = s1_q[22:0];
    fw       = (fw_q > 5'd23) ? 5'd23 : fw_q;
    sh       = 5'd23 - fw;
    is_pass  = (s1_q[30:0] == 31'd0) || (bexp == 8'hFF && frac != 23'd0);
    emax_raw = $signed({1'b0, 9'((10'd1 << ew_q) - 10'd1)}) - $signed({2'b00, bias_q});
    emin_raw = -$signed({2'b00, bias_q});
    emax     = sat(emax_raw);
    emin     = sat(emin_raw);
    if (bexp == 8'd0) e = -10'sd127;
    else if (bexp == 8'hFF) e = 10'sd128;
    else e = $signed({2'b00, bexp}) - 10'sd127;
    ewk = (e < emax) ? e : emax;
    if (ewk < emin) ewk = emin;
    ep1 = ewk + 10'sd1;
    eo  = (ep1 < emax) ? ep1 : emax;
    if (eo < emin) eo = emin;
    fmask = 23'h7FFFFF << sh;
    half  = (sh == 5'd0) ? 23'd0 : (23'd1 << (sh - 5'd1));
    // Round half away from zero in place: add half an ulp, drop low bits.
    m = ({1'b0, frac} + {1'b0, half}) & {1'b1, fmask};
    if (e < ewk) begin
      eres = ewk; fres = 23'd0;
    end else if (e > ewk || m[23]) begin
      eres = eo;  fres = 23'd0;
    end else begin
      eres = ewk; fres = m[22:0];
    end
    res_d = is_pass ? s1_q : {s1_q[31], 8'(eres + 10'sd127), fres};
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) out_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = out_q;

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q)) else $error("result lost");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q) else $error("needless stall");
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_adv |=> out_valid_q) else $error("item dropped");
endmodule

// ===== verif/tb_float32_minifloat_round.sv =====
// Testbench for float32_minifloat_round: drives float32 patterns through the
// rounding block under random gaps and output stalls, predicts each rounded value.
// Depends on fmr_pkg and the float32_minifloat_round RTL.
`timescale 1ns / 1ps

class round_scoreboard;
  logic [3:0]  exp_width;
  logic [4:0]  frac_width;
  logic [7:0]  exp_bias;
  logic [31:0] pending_q[$];
  int          fail_count;

  function new();
    exp_width  = fmr_pkg::ExpWidthRst;
    frac_width = fmr_pkg::FracWidthRst;
    exp_bias   = fmr_pkg::ExpBiasRst;
    fail_count = 0;
  endfunction

  function int clamp_exp(int v);
    if (v < -126) return -126;
    if (v > 127) return 127;
    return v;
  endfunction

  function logic [31:0] pack_fp(logic sgn, int e, logic [22:0] frac);
    logic [7:0] be;
    be = 8'(e + 127);
    return {sgn, be, frac};
  endfunction

  // Round one float32 pattern onto the current grid.
  function logic [31:0] round_value(logic [31:0] x);
    logic        sgn;
    logic [7:0]  bexp;
    logic [22:0] frac;
    int          fw, sh, emax, emin, e, ew, eo;
    logic [31:0] m;
    sgn  = x[31];
    bexp = x[30:23];
    frac = x[22:0];
    if (x[30:0] == 0 || (bexp == 8'hFF && frac != 0)) return x;
    fw   = (frac_width > 23) ? 23 : int'(frac_width);
    emax = clamp_exp(((1 << exp_width) - 1) - int'(exp_bias));
    emin = clamp_exp(-int'(exp_bias));
    if (bexp == 0) e = -127;
    else if (bexp == 8'hFF) e = 128;
    else e = int'(bexp) - 127;
    ew = (e < emax) ? e : emax;
    if (ew < emin) ew = emin;
    eo = (ew + 1 < emax) ? ew + 1 : emax;
    if (eo < emin) eo = emin;
    if (e < ew) return pack_fp(sgn, ew, 0);
    if (e > ew) return pack_fp(sgn, eo, 0);
    sh = 23 - fw;
    if (sh == 0) m = frac;
    else begin
      m = frac >> sh;
      if ((frac >> (sh - 1)) & 1) m++;
    end
    if (m >= (32'd1 << fw)) return pack_fp(sgn, eo, 0);
    return pack_fp(sgn, ew, 23'(m << sh));
  endfunction

  function void note_input(logic [31:0] x);
    pending_q.push_back(round_value(x));
  endfunction

  function void check_result(logic [31:0] got);
    logic [31:0] want;
    if (pending_q.size() == 0) begin
      $error("value_out: no result expected, actual %h", got);
      fail_count++;
      return;
    end
    want = pending_q.pop_front();
    if (want !== got) begin
      $error("value_out: expected %h actual %h", want, got);
      fail_count++;
    end
  endfunction
endclass

module tb_float32_minifloat_round;
  import fmr_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] value_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] value_out_o;

  round_scoreboard rounding_sb = new();
  int  hold_off_cycles = 0;  // long receiver hold-off, counted in the sink

  always #4 clk_i = ~clk_i;

  float32_minifloat_round dut (.*);

  // Check every result transfer; sampled at the edge, so no race with drivers.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) rounding_sb.check_result(value_out_o);
  end

  // Sink: random stall per result, plus one long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_off_cycles--;
      end else if (out_valid_o && !out_stall_i) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Write one format register; only called while the block is idle.
  // Valid stays high so writes can follow back to back.
  task automatic write_format(cfg_idx_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_EXP_WIDTH:  rounding_sb.exp_width  = data[3:0];
      CFG_FRAC_WIDTH: rounding_sb.frac_width = data[4:0];
      CFG_EXP_BIAS:   rounding_sb.exp_bias   = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_format(int ew, int fw, int bias);
    write_format(CFG_EXP_WIDTH, ew);
    write_format(CFG_FRAC_WIDTH, fw);
    write_format(CFG_EXP_BIAS, bias);
    cfg_valid_i <= 1'b0;
  endtask

  // Send one value; gap drawn per item, busy streak keeps valid high.
  task automatic send_value(logic [31:0] x, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_in_i <= x;
    do @(posedge clk_i); while (in_stall_o);
    rounding_sb.note_input(x);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
  endtask

  // Drain: stop sending, wait until all results are back, then idle before the next phase.
  task automatic drain();
    end_burst();
    @(posedge clk_i);
    while (rounding_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random float32: mostly normals near the grid range, some specials.
  function automatic logic [31:0] random_value();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0: r[30:23] = 8'hFF;                       // inf or NaN
      1: r[30:23] = 8'h00;                       // zero or subnormal
      2: r[30:0]  = '0;                          // signed zero
      3, 4: r[30:23] = 8'(127 + $signed($urandom_range(0, 20)) - 10);
      5: r[22:0] = {r[22:20], 20'h80000 >> $urandom_range(0, 19)}; // near ties
      default: ;
    endcase
    return r;
  endfunction

  task automatic random_phase(int count);
    bit streak;
    for (int i = 0; i < count; i++) begin
      streak = ($urandom_range(0, 3) == 0);
      send_value(random_value(), streak);
    end
    drain();
  endtask

  initial begin
    logic [31:0] directed[$];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zeros, NaN, infinities, subnormals, extremes, ties, carries.
    directed = '{32'h00000000, 32'h80000000, 32'h7FC00000, 32'hFF800001,
                 32'h7F800000, 32'hFF800000, 32'h00000001, 32'h807FFFFF,
                 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00800000, 32'h3F800000,
                 32'h3FC00000, 32'hBFC00000, 32'h3FFFFFFF, 32'h40400000,
                 32'h41200000, 32'hC7000000, 32'h3E800000, 32'h3F7FFFFF};
    foreach (directed[i]) send_value(directed[i], 1'b0);
    drain();
    set_format(4, 3, 7);                            // fp8-like
    foreach (directed[i]) send_value(directed[i], 1'b1);
    drain();
    set_format(1, 0, 255);                          // collapsed range: emin and emax both saturate to -126
    foreach (directed[i]) send_value(directed[i], 1'b0);
    drain();

    // Random phases across settings, extremes among them.
    set_format(15, 31, 0);     random_phase(150);
    set_format(5, 2, 15);      random_phase(200);
    set_format(8, 23, 127);    random_phase(150);
    set_format(0, 10, 3);      random_phase(150);
    set_format(2, 1, 1);       random_phase(150);

    // Long receiver hold-off while the sender keeps offering.
    hold_off_cycles = 60;
    random_phase(100);

    for (int k = 0; k < 8; k++) begin
      set_format($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 255));
      random_phase(100);
    end
    repeat (10) @(posedge clk_i);
    if (rounding_sb.fail_count == 0 && rounding_sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
